// ===== hw/rtl/sha1sh_pkg.sv =====
`timescale 1ns / 1ps

package sha1sh_pkg;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_ROUND  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      CMD_ABSORB  = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   // five 32-bit hash words, index 0 is H0
   typedef logic [4:0][31:0] hword_type;
   // sixteen-word schedule window, index 0 is w[t]
   typedef logic [15:0][31:0] sched_type;

   localparam hword_type SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                    32'hEFCDAB89, 32'h67452301};

   localparam logic [31:0] K_00_19 = 32'h5A827999;
   localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
   localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
   localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

   localparam logic [7:0]  PAD_BYTE  = 8'h80;
   localparam logic [31:0] LO_LIMIT  = 32'hFFFF_FFF8;
   localparam logic [31:0] CNT_STEP  = 32'd8;
   localparam logic [31:0] HI_MAX    = 32'hFFFF_FFFF;

   localparam int unsigned NUM_ROUNDS  = 80;
   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned LEN_START   = 56;

   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [6:0] RND_20     = 7'd20;
   localparam logic [6:0] RND_40     = 7'd40;
   localparam logic [6:0] RND_60     = 7'd60;
   localparam logic [5:0] LAST_FILL  = 6'd63;

   function automatic logic [31:0] byte_rev(input logic [31:0] v);
      byte_rev = {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// ===== hw/rtl/sha1_stream_hasher_unit.sv =====
`timescale 1ns / 1ps

// Streaming SHA-1 hasher. Send message bytes with command absorb, one per item; a
// read item returns the digest of everything absorbed since the last restart (the
// message is padded on a copy, so absorbing can continue afterwards) plus a sticky
// flag that is set once the 64-bit bit count has overflowed. Restart reloads the IV.
// An absorb item that does not complete a 64-byte block leaves req_ready high. An
// absorb that completes a block keeps req_ready low after acceptance through load,
// 80 rounds and chain add. A read runs load, 80 rounds and a finish step before its
// result, twice when 56 or more bytes of the current block are buffered (padding
// spills into a second block); finish waits until an earlier result is taken. One
// round datapath does one round per clock. Restart and the unused command give no
// result. csr_wr_data set to 1 byte-reverses each digest word on the rsp ports.

module sha1_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3,
   output logic [31:0] rsp_digest_word4,
   output logic        rsp_length_overflow,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   // ---------------------------------------------------------------- registers
   sha1sh_pkg::state_type state_ff, state_in;
   logic [5:0]            fill_ff, fill_in;        // bytes in current block
   logic [31:0]           cnt_hi_ff, cnt_hi_in;    // message bit count, high half
   logic [31:0]           cnt_lo_ff, cnt_lo_in;    // message bit count, low half
   logic                  ovf_ff, ovf_in;          // sticky count overflow
   logic                  word_order_ff;
   sha1sh_pkg::hword_type chain_ff, chain_in;      // live chain value
   sha1sh_pkg::hword_type hash_ff, hash_in;        // digest copy / result words
   sha1sh_pkg::hword_type work_ff, work_in;        // a..e, index 0 is a
   sha1sh_pkg::sched_type w_ff, w_in;              // message schedule window
   logic [6:0]            rnd_ff, rnd_in;
   logic                  mode_read_ff, mode_read_in;  // compression serves a read
   logic                  pass2_ff, pass2_in;          // length-only second block
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   sha1sh_pkg::sched_type buf_ff;                  // block bytes, big-endian per word

   // ---------------------------------------------------------------- combinational
   logic                  req_accept;
   sha1sh_pkg::cmd_type   req_cmd;
   logic                  need2;
   logic [63:0]           len64;
   logic [7:0]            pad_b [sha1sh_pkg::BLOCK_BYTES];
   sha1sh_pkg::sched_type block_w;
   sha1sh_pkg::hword_type base_h;
   sha1sh_pkg::hword_type sum_h;
   logic [31:0]           f_val;
   logic [31:0]           k_val;
   logic [31:0]           t_val;
   logic [31:0]           w_mix;

   assign req_ready  = (state_ff == sha1sh_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign req_cmd    = sha1sh_pkg::cmd_type'(req_command);

   // padding needs a second block once 56 or more bytes are buffered
   assign need2 = (fill_ff[5:3] == 3'b111);
   assign len64 = {cnt_hi_ff, cnt_lo_ff};

   // block fed to the compressor: raw buffer for absorb, padded copy for read
   always_comb begin
      for (int i = 0; i < sha1sh_pkg::BLOCK_BYTES; i++) begin
         if (!mode_read_ff) begin
            pad_b[i] = buf_ff[i / 4][8 * (3 - i % 4) +: 8];
         end else if (pass2_ff) begin
            pad_b[i] = (i >= sha1sh_pkg::LEN_START) ? len64[8*(63-i) +: 8] : 8'h00;
         end else begin
            if (6'(i) < fill_ff) begin
               pad_b[i] = buf_ff[i / 4][8 * (3 - i % 4) +: 8];
            end else if (6'(i) == fill_ff) begin
               pad_b[i] = sha1sh_pkg::PAD_BYTE;
            end else begin
               pad_b[i] = 8'h00;
            end
            if (i >= sha1sh_pkg::LEN_START && !need2) begin
               pad_b[i] = len64[8*(63-i) +: 8];
            end
         end
      end
      for (int j = 0; j < sha1sh_pkg::BLOCK_WORDS; j++) begin
         block_w[j] = {pad_b[4*j], pad_b[4*j+1], pad_b[4*j+2], pad_b[4*j+3]};
      end
   end

   // second pass of a read chains from the first pass result
   assign base_h = (mode_read_ff && pass2_ff) ? hash_ff : chain_ff;

   always_comb begin
      for (int k = 0; k < 5; k++) begin
         sum_h[k] = base_h[k] + work_ff[k];
      end
   end

   // round function
   always_comb begin
      if (rnd_ff < sha1sh_pkg::RND_20) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = sha1sh_pkg::K_00_19;
      end else if (rnd_ff < sha1sh_pkg::RND_40) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = sha1sh_pkg::K_20_39;
      end else if (rnd_ff < sha1sh_pkg::RND_60) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                 (work_ff[2] & work_ff[3]);
         k_val = sha1sh_pkg::K_40_59;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = sha1sh_pkg::K_60_79;
      end
      t_val = {work_ff[0][26:0], work_ff[0][31:27]} + f_val + work_ff[4] + k_val + w_ff[0];
      w_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   end

   // sequencer and state update
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cnt_hi_in    = cnt_hi_ff;
      cnt_lo_in    = cnt_lo_ff;
      ovf_in       = ovf_ff;
      chain_in     = chain_ff;
      hash_in      = hash_ff;
      work_in      = work_ff;
      w_in         = w_ff;
      rnd_in       = rnd_ff;
      mode_read_in = mode_read_ff;
      pass2_in     = pass2_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sha1sh_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_cmd)
                  sha1sh_pkg::CMD_ABSORB: begin
                     fill_in = fill_ff + 6'd1;
                     if (cnt_lo_ff < sha1sh_pkg::LO_LIMIT) begin
                        cnt_lo_in = cnt_lo_ff + sha1sh_pkg::CNT_STEP;
                     end else begin
                        cnt_lo_in = '0;
                        if (cnt_hi_ff != sha1sh_pkg::HI_MAX) begin
                           cnt_hi_in = cnt_hi_ff + 32'd1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                     if (fill_ff == sha1sh_pkg::LAST_FILL) begin
                        mode_read_in = 1'b0;
                        pass2_in     = 1'b0;
                        state_in     = sha1sh_pkg::ST_LOAD;
                     end
                  end
                  sha1sh_pkg::CMD_READ: begin
                     mode_read_in = 1'b1;
                     pass2_in     = 1'b0;
                     state_in     = sha1sh_pkg::ST_LOAD;
                  end
                  sha1sh_pkg::CMD_RESTART: begin
                     chain_in  = sha1sh_pkg::SHA1_IV;
                     fill_in   = '0;
                     cnt_hi_in = '0;
                     cnt_lo_in = '0;
                     ovf_in    = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sha1sh_pkg::ST_LOAD: begin
            w_in     = block_w;
            work_in  = base_h;
            rnd_in   = '0;
            state_in = sha1sh_pkg::ST_ROUND;
         end
         sha1sh_pkg::ST_ROUND: begin
            work_in = {work_ff[3], work_ff[2], {work_ff[1][1:0], work_ff[1][31:2]},
                       work_ff[0], t_val};
            w_in    = {{w_mix[30:0], w_mix[31]}, w_ff[15:1]};
            rnd_in  = rnd_ff + 7'd1;
            if (rnd_ff == sha1sh_pkg::LAST_ROUND) begin
               state_in = sha1sh_pkg::ST_FINISH;
            end
         end
         sha1sh_pkg::ST_FINISH: begin
            if (!mode_read_ff) begin
               chain_in = sum_h;
               state_in = sha1sh_pkg::ST_IDLE;
            end else if (!(rsp_valid_ff && !rsp_ready)) begin
               // hash_ff doubles as the result register: wait for the old result
               hash_in = sum_h;
               if (!pass2_ff && need2) begin
                  pass2_in = 1'b1;
                  state_in = sha1sh_pkg::ST_LOAD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_ovf_in   = ovf_ff;
                  state_in     = sha1sh_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha1sh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sha1sh_pkg::ST_IDLE;
         fill_ff       <= '0;
         cnt_hi_ff     <= '0;
         cnt_lo_ff     <= '0;
         ovf_ff        <= 1'b0;
         chain_ff      <= sha1sh_pkg::SHA1_IV;
         mode_read_ff  <= 1'b0;
         pass2_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         word_order_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_hi_ff    <= cnt_hi_in;
         cnt_lo_ff    <= cnt_lo_in;
         ovf_ff       <= ovf_in;
         chain_ff     <= chain_in;
         mode_read_ff <= mode_read_in;
         pass2_ff     <= pass2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            word_order_ff <= csr_wr_data;
         end
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      hash_ff    <= hash_in;
      work_ff    <= work_in;
      w_ff       <= w_in;
      rnd_ff     <= rnd_in;
      rsp_ovf_ff <= rsp_ovf_in;
      if (req_accept && req_cmd == sha1sh_pkg::CMD_ABSORB) begin
         // byte 0 of a word sits in its top lane
         buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= req_data_byte;
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_length_overflow = rsp_ovf_ff;
   assign rsp_digest_word0 = word_order_ff ? sha1sh_pkg::byte_rev(hash_ff[0]) : hash_ff[0];
   assign rsp_digest_word1 = word_order_ff ? sha1sh_pkg::byte_rev(hash_ff[1]) : hash_ff[1];
   assign rsp_digest_word2 = word_order_ff ? sha1sh_pkg::byte_rev(hash_ff[2]) : hash_ff[2];
   assign rsp_digest_word3 = word_order_ff ? sha1sh_pkg::byte_rev(hash_ff[3]) : hash_ff[3];
   assign rsp_digest_word4 = word_order_ff ? sha1sh_pkg::byte_rev(hash_ff[4]) : hash_ff[4];

   // ---------------------------------------------------------------- assertions
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1sh_pkg::ST_ROUND |-> rnd_ff <= sha1sh_pkg::LAST_ROUND)
      else $error("round counter past last round");

   a_pass2_only_spill: assert property (@(posedge clock) disable iff (reset)
      pass2_ff && state_ff != sha1sh_pkg::ST_IDLE |-> mode_read_ff && need2)
      else $error("second padding block without spill");

   a_block_full_compress: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_cmd == sha1sh_pkg::CMD_ABSORB && fill_ff == sha1sh_pkg::LAST_FILL
      |=> state_ff == sha1sh_pkg::ST_LOAD && fill_ff == 6'd0)
      else $error("full block did not start compression");

   a_read_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_cmd == sha1sh_pkg::CMD_READ |=> !$rose(rsp_valid_ff))
      else $error("result raised before compression");

endmodule
